>>> hw/rtl/eckd_block_to_cchhr_macros.svh
// ---------------------------------------------------------------------------
// eckd_block_to_cchhr_macros
// Assertion helpers used by the block's top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef ECKD_BLOCK_TO_CCHHR_MACROS_SVH
`define ECKD_BLOCK_TO_CCHHR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ECKD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ECKD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/eckd_b2c_pkg.sv
// ---------------------------------------------------------------------------
// eckd_b2c_pkg
// Shared types, constants and constant-divide helpers for the CCHHR block.
// ---------------------------------------------------------------------------
package eckd_b2c_pkg;

    localparam int C_TPC_W    = 16;
    localparam int C_KEY_W    = 8;
    localparam int C_DATA_W   = 16;
    localparam int C_LBA_W    = 31;
    localparam int C_CELLS_W  = 12;
    localparam int C_RPT_W    = 16;
    localparam int C_TCELLS_W = 16;
    localparam int C_TRACK_CELLS = 1729;

    localparam logic [C_TPC_W-1:0]  C_TPC_RESET  = 16'd15;
    localparam logic [C_KEY_W-1:0]  C_KEY_RESET  = 8'd0;
    localparam logic [C_DATA_W-1:0] C_DATA_RESET = 16'd4096;

    // Reciprocals for exact floor division of 17-bit values.
    localparam int C_K232 = 26;
    localparam logic [19:0] C_M232 = 20'((64'd1 << C_K232) / 232 + 1);
    localparam int C_K34 = 24;
    localparam logic [19:0] C_M34 = 20'((64'd1 << C_K34) / 34 + 1);

    typedef enum logic [1:0] {
        CFG_TPC  = 2'd0,
        CFG_KEY  = 2'd1,
        CFG_DATA = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ERR_OK           = 2'd0,
        ERR_NO_RECORDS   = 2'd1,
        ERR_CYL_OVERFLOW = 2'd2
    } t_err;

    // Ceiling of x / 232.
    function automatic logic [8:0] f_ceil_232(input logic [16:0] x);
        logic [16:0] s;
        logic [36:0] p;
        s = x + 17'd231;
        p = {20'd0, s} * {17'd0, C_M232};
        return p[C_K232 +: 9];
    endfunction

    // Ceiling of x / 34.
    function automatic logic [10:0] f_ceil_34(input logic [16:0] x);
        logic [16:0] s;
        logic [36:0] p;
        s = x + 17'd33;
        p = {20'd0, s} * {17'd0, C_M34};
        return p[C_K34 +: 11];
    endfunction

endpackage

>>> hw/rtl/eckd_b2c_cap.sv
// ---------------------------------------------------------------------------
// eckd_b2c_cap
// Three-stage track capacity front end: cells used by one record.
// ---------------------------------------------------------------------------
module eckd_b2c_cap (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [eckd_b2c_pkg::C_LBA_W-1:0]   i_lba,
    input  logic [eckd_b2c_pkg::C_KEY_W-1:0]   i_key_length,
    input  logic [eckd_b2c_pkg::C_DATA_W-1:0]  i_data_length,
    output logic                           o_valid,
    output logic [eckd_b2c_pkg::C_LBA_W-1:0]   o_lba,
    output logic [eckd_b2c_pkg::C_CELLS_W-1:0] o_cells
);
    import eckd_b2c_pkg::*;

    logic                 r_v1, r_v2, r_v3;
    logic [C_LBA_W-1:0]   r_lba1, r_lba2, r_lba3;
    logic [8:0]           r_dn, r_kn;
    logic [10:0]          r_dc, r_kc;
    logic [C_CELLS_W-1:0] r_cells;
    logic [C_CELLS_W-1:0] n_cells;

    // Key area adds its own overhead only for keyed records.
    always_comb begin
        n_cells = C_CELLS_W'(12'd19 + {1'b0, r_dc});
        if (i_key_length != '0) begin
            n_cells = n_cells + C_CELLS_W'(12'd9 + {1'b0, r_kc});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lba1  <= i_lba;
            r_dn    <= f_ceil_232({1'b0, i_data_length} + 17'd6) + 9'd1;
            r_kn    <= f_ceil_232({9'd0, i_key_length} + 17'd6) + 9'd1;
            r_lba2  <= r_lba1;
            r_dc    <= f_ceil_34({1'b0, i_data_length} + 17'({r_dn, 1'b0} + {r_dn, 2'b0}));
            r_kc    <= f_ceil_34({9'd0, i_key_length} + 17'({r_kn, 1'b0} + {r_kn, 2'b0}));
            r_lba3  <= r_lba2;
            r_cells <= n_cells;
        end
    end

    assign o_valid = r_v3;
    assign o_lba   = r_lba3;
    assign o_cells = r_cells;

endmodule

>>> hw/rtl/eckd_b2c_div.sv
// ---------------------------------------------------------------------------
// eckd_b2c_div
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ---------------------------------------------------------------------------
module eckd_b2c_div #(
    parameter int NW = 31,
    parameter int DW = 16,
    parameter int PW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [PW-1:0] o_pay
);

    logic          r_v   [NW];
    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [DW-1:0] r_den [NW];
    logic [PW-1:0] r_pay [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          s_v;
        logic [DW-1:0] s_rem;
        logic [NW-1:0] s_num;
        logic [DW-1:0] s_den;
        logic [PW-1:0] s_pay;
        logic [DW:0]   w_trial;
        logic [DW:0]   w_diff;
        logic          w_ge;
        logic [DW-1:0] n_rem;
        logic [NW-1:0] n_num;

        if (k == 0) begin : g_first
            assign s_v   = i_valid;
            assign s_rem = '0;
            assign s_num = i_num;
            assign s_den = i_den;
            assign s_pay = i_pay;
        end else begin : g_next
            assign s_v   = r_v[k-1];
            assign s_rem = r_rem[k-1];
            assign s_num = r_num[k-1];
            assign s_den = r_den[k-1];
            assign s_pay = r_pay[k-1];
        end

        always_comb begin
            w_trial = {s_rem, s_num[NW-1]};
            w_diff  = w_trial - {1'b0, s_den};
            w_ge    = (w_trial >= {1'b0, s_den});
            n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            n_num   = {s_num[NW-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= s_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_num[k] <= n_num;
                r_den[k] <= s_den;
                r_pay[k] <= s_pay;
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quo   = r_num[NW-1];
    assign o_rem   = r_rem[NW-1];
    assign o_pay   = r_pay[NW-1];

endmodule

>>> hw/rtl/eckd_block_to_cchhr.sv
// ---------------------------------------------------------------------------
// eckd_block_to_cchhr
// Linear block number to 3390 ECKD cylinder, head, record and CCHHR argument.
// ---------------------------------------------------------------------------
// Usage. Block numbers arrive as words on the slave stream (31 bits in
// tdata). Each one yields exactly one result word on the master stream:
// cylinder, head, record (from one), the packed CCHHR search argument and
// the records per track, with an error code in tuser.
// The configuration port sets tracks per cylinder, key length and data
// length; the user must write it only while no word is in flight (unchecked).
// The pipeline has three stages of track capacity arithmetic, a 16-stage
// divider for records per track, a 31-stage divider for track index and
// record slot, a 31-stage divider for cylinder and head, and the output
// register. Throughput is one word per cycle unless the receiver stalls;
// every stage holds one word and the whole pipeline advances together.
// Reset empties the pipeline and loads the registers with 15 heads, no key
// and 4096-byte records. When the receiver stalls with a result held, the
// pipeline freezes and tready falls; nothing is lost or repeated, and it
// resumes the cycle the result is taken.
// ---------------------------------------------------------------------------
`include "eckd_block_to_cchhr_macros.svh"

module eckd_block_to_cchhr #(
    parameter int TRACK_CELLS = eckd_b2c_pkg::C_TRACK_CELLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream: tdata [30:0] lba, [31] zero.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,
    // Master stream: tdata [15:0] cylinder, [31:16] head, [39:32] record,
    // [79:40] search_argument, [86:80] records_per_track, [87] zero.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [87:0] o_m_axis_tdata,
    // tuser [1:0] error.
    output logic [1:0]  o_m_axis_tuser,
    // Configuration write port.
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);
    import eckd_b2c_pkg::*;

    // Configuration registers.
    logic [C_TPC_W-1:0]  r_tpc;
    logic [C_KEY_W-1:0]  r_key;
    logic [C_DATA_W-1:0] r_data;
    logic [C_TPC_W-1:0]  w_tpc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpc  <= C_TPC_RESET;
            r_key  <= C_KEY_RESET;
            r_data <= C_DATA_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TPC:  r_tpc  <= i_cfg_wdata;
                CFG_KEY:  r_key  <= i_cfg_wdata[C_KEY_W-1:0];
                CFG_DATA: r_data <= i_cfg_wdata;
                default:  ;
            endcase
        end
    end

    // A cylinder of zero heads is treated as one head.
    assign w_tpc = (r_tpc == '0) ? C_TPC_W'(1) : r_tpc;

    // The whole pipeline moves whenever the output register can take a word.
    logic r_out_v;
    logic w_en;
    assign w_en            = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Track capacity front end.
    logic                 cap_v;
    logic [C_LBA_W-1:0]   cap_lba;
    logic [C_CELLS_W-1:0] cap_cells;

    eckd_b2c_cap u_cap (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_s_axis_tvalid),
        .i_lba         (i_s_axis_tdata[C_LBA_W-1:0]),
        .i_key_length  (r_key),
        .i_data_length (r_data),
        .o_valid       (cap_v),
        .o_lba         (cap_lba),
        .o_cells       (cap_cells)
    );

    // Records per track: track cells over cells per record.
    logic                 a_v;
    logic [C_RPT_W-1:0]   a_rpt;
    logic [C_CELLS_W-1:0] a_rem;
    logic [C_LBA_W-1:0]   a_lba;

    eckd_b2c_div #(.NW(C_TCELLS_W), .DW(C_CELLS_W), .PW(C_LBA_W)) u_div_rpt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (cap_v),
        .i_num   (C_TCELLS_W'(TRACK_CELLS)),
        .i_den   (cap_cells),
        .i_pay   (cap_lba),
        .o_valid (a_v),
        .o_quo   (a_rpt),
        .o_rem   (a_rem),
        .o_pay   (a_lba)
    );

    // Track index and record slot: block number over records per track.
    logic               b_v;
    logic [C_LBA_W-1:0] b_trk;
    logic [C_RPT_W-1:0] b_slot;
    logic [C_RPT_W-1:0] b_rpt;

    eckd_b2c_div #(.NW(C_LBA_W), .DW(C_RPT_W), .PW(C_RPT_W)) u_div_rec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (a_v),
        .i_num   (a_lba),
        .i_den   (a_rpt),
        .i_pay   (a_rpt),
        .o_valid (b_v),
        .o_quo   (b_trk),
        .o_rem   (b_slot),
        .o_pay   (b_rpt)
    );

    // Cylinder and head: track index over tracks per cylinder.
    logic                   c_v;
    logic [C_LBA_W-1:0]     c_cyl;
    logic [C_TPC_W-1:0]     c_head;
    logic [2*C_RPT_W-1:0]   c_pay;

    eckd_b2c_div #(.NW(C_LBA_W), .DW(C_TPC_W), .PW(2*C_RPT_W)) u_div_cyl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (b_v),
        .i_num   (b_trk),
        .i_den   (w_tpc),
        .i_pay   ({b_rpt, b_slot}),
        .o_valid (c_v),
        .o_quo   (c_cyl),
        .o_rem   (c_head),
        .o_pay   (c_pay)
    );

    // Output stage: classify, zero the fields on error and pack.
    logic [C_RPT_W-1:0] w_rpt;
    logic [C_RPT_W-1:0] w_slot;
    t_err               n_err;
    logic [15:0]        n_cyl;
    logic [15:0]        n_head;
    logic [7:0]         n_rec;
    logic [87:0]        n_tdata;
    logic [87:0]        r_tdata;
    t_err               r_err;

    assign w_rpt  = c_pay[2*C_RPT_W-1:C_RPT_W];
    assign w_slot = c_pay[C_RPT_W-1:0];

    always_comb begin
        n_cyl  = '0;
        n_head = '0;
        n_rec  = '0;
        if (w_rpt == '0) begin
            n_err = ERR_NO_RECORDS;
        end else if (c_cyl[C_LBA_W-1:16] != '0) begin
            n_err = ERR_CYL_OVERFLOW;
        end else begin
            n_err  = ERR_OK;
            n_cyl  = c_cyl[15:0];
            n_head = c_head;
            n_rec  = w_slot[7:0] + 8'd1;
        end
        n_tdata = {1'b0, w_rpt[6:0], n_cyl, n_head, n_rec, n_rec, n_head, n_cyl};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tdata <= n_tdata;
            r_err   <= n_err;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_tdata;
    assign o_m_axis_tuser  = r_err;

    // A track with no room for a record reports nothing but the code.
    `ECKD_ASSERT_IMP(a_no_rec_zero, i_clk, i_rst_n,
        r_out_v && (r_err == ERR_NO_RECORDS), r_tdata == '0, "fields set without records")

    // The search argument always mirrors cylinder, head and record.
    `ECKD_ASSERT_IMP(a_sarg_match, i_clk, i_rst_n, r_out_v,
        (r_tdata[79:64] == r_tdata[15:0]) && (r_tdata[63:48] == r_tdata[31:16]) &&
        (r_tdata[47:40] == r_tdata[39:32]), "search argument mismatch")

    // An overflowed cylinder leaves cylinder, head and record cleared.
    `ECKD_ASSERT_IMP(a_ovf_rpt, i_clk, i_rst_n,
        r_out_v && (r_err == ERR_CYL_OVERFLOW), r_tdata[39:0] == '0, "overflow with fields")

endmodule
